@@ hw/rtl/rac_pkg.sv @@
// rac_pkg: shared types and constants for the rotate-add checksum engine
// no dependencies; used by the interfaces, rac_fold and the top level
package rac_pkg;

  typedef enum logic [1:0] {
    MODE_BOOT  = 2'd0,
    MODE_SET   = 2'd1,
    MODE_PLAIN = 2'd2,
    MODE_ALT   = 2'd3
  } mode_t;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned SUM_W      = 32;
  localparam int unsigned HALF_W     = 16;
  localparam int unsigned SET_LEN_W  = 14;
  localparam int unsigned ENTRY_SH   = 5;

  // boot region bytes left out of the sum
  localparam int unsigned BOOT_SKIP_A = 106;
  localparam int unsigned BOOT_SKIP_B = 107;
  localparam int unsigned BOOT_SKIP_C = 112;
  // entry set header bytes
  localparam int unsigned SET_LEN_POS = 1;
  localparam int unsigned SET_SKIP_A  = 2;
  localparam int unsigned SET_SKIP_B  = 3;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              first_byte;
    logic              last_byte;
  } beat_t;

  typedef struct packed {
    logic             emit;
    logic [SUM_W-1:0] checksum_value;
    logic             short_set;
  } fold_res_t;

endpackage

@@ hw/rtl/rac_in_if.sv @@
// rac_in_if: input byte channel, valid/ready with the beat payload
// depends on rac_pkg
interface rac_in_if;
  logic                      valid;
  logic                      ready;
  logic [rac_pkg::BYTE_W-1:0] data_byte;
  logic                      first_byte;
  logic                      last_byte;

  modport source (output valid, data_byte, first_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

@@ hw/rtl/rac_out_if.sv @@
// rac_out_if: result channel, valid/ready with the finished checksum
// depends on rac_pkg
interface rac_out_if;
  logic                      valid;
  logic                      ready;
  logic [rac_pkg::SUM_W-1:0] checksum_value;
  logic                      short_set;

  modport source (output valid, checksum_value, short_set, input ready);
  modport sink   (input valid, checksum_value, short_set, output ready);
endinterface

@@ hw/rtl/rac_fold.sv @@
// rac_fold: message state and the rotate-add step for one registered beat
// depends on rac_pkg
module rac_fold #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rac_pkg::mode_t    mode,
  input  rac_pkg::beat_t    beat,
  input  logic              beat_valid,
  input  logic              advance,
  output rac_pkg::fold_res_t res
);

  logic [rac_pkg::SUM_W-1:0]     sum_r,  sum_nxt;
  logic [POSITION_BITS-1:0]      pos_r,  pos_nxt;
  logic [rac_pkg::SET_LEN_W-1:0] slen_r, slen_nxt;
  logic                          open_r, open_nxt;

  logic [rac_pkg::SUM_W-1:0]     sum_cur, rot32;
  logic [rac_pkg::HALF_W-1:0]    half, rot16, add16;
  logic [POSITION_BITS-1:0]      pos_cur;
  logic [POSITION_BITS:0]        pos_inc;
  logic [rac_pkg::SET_LEN_W-1:0] slen_cur;
  logic                          open_cur, set_done, boot_skip, set_skip;

  always_comb begin
    sum_cur  = beat.first_byte ? '0 : sum_r;
    pos_cur  = beat.first_byte ? '0 : pos_r;
    slen_cur = beat.first_byte ? '0 : slen_r;
    open_cur = beat.first_byte | open_r;

    rot32 = {sum_cur[0], sum_cur[rac_pkg::SUM_W-1:1]};
    half  = sum_cur[rac_pkg::HALF_W-1:0];
    rot16 = {half[0], half[rac_pkg::HALF_W-1:1]};
    add16 = rot16 + rac_pkg::HALF_W'(beat.data_byte);
    pos_inc = {1'b0, pos_cur} + (POSITION_BITS+1)'(1);

    boot_skip = (pos_cur == POSITION_BITS'(rac_pkg::BOOT_SKIP_A)) ||
                (pos_cur == POSITION_BITS'(rac_pkg::BOOT_SKIP_B)) ||
                (pos_cur == POSITION_BITS'(rac_pkg::BOOT_SKIP_C));
    set_skip  = (pos_cur == POSITION_BITS'(rac_pkg::SET_SKIP_A)) ||
                (pos_cur == POSITION_BITS'(rac_pkg::SET_SKIP_B));

    sum_nxt  = sum_cur;
    slen_nxt = slen_cur;
    open_nxt = open_cur;
    // position saturates at all ones
    pos_nxt  = (&pos_cur) ? pos_cur : pos_inc[POSITION_BITS-1:0];
    set_done = 1'b0;

    res.emit           = 1'b0;
    res.checksum_value = '0;
    res.short_set      = 1'b0;

    case (mode)
      rac_pkg::MODE_SET: begin
        if (pos_cur == POSITION_BITS'(rac_pkg::SET_LEN_POS)) begin
          // (1 + entry count) * 32 bytes
          slen_nxt = {(9'(beat.data_byte) + 9'd1), {rac_pkg::ENTRY_SH{1'b0}}};
        end
        if (set_skip) begin
          sum_nxt = {{(rac_pkg::SUM_W-rac_pkg::HALF_W){1'b0}}, half};
        end else begin
          sum_nxt = {{(rac_pkg::SUM_W-rac_pkg::HALF_W){1'b0}}, add16};
        end
        set_done = (slen_nxt != '0) &&
                   (pos_inc >= (POSITION_BITS+1)'(slen_nxt));
        res.emit           = set_done | beat.last_byte;
        res.checksum_value = sum_nxt;
        res.short_set      = ~set_done;
      end
      rac_pkg::MODE_BOOT: begin
        if (!boot_skip) begin
          sum_nxt = rot32 + rac_pkg::SUM_W'(beat.data_byte);
        end
        res.emit           = beat.last_byte;
        res.checksum_value = sum_nxt;
      end
      default: begin
        sum_nxt            = rot32 + rac_pkg::SUM_W'(beat.data_byte);
        res.emit           = beat.last_byte;
        res.checksum_value = sum_nxt;
      end
    endcase

    // a stray beat with no open message changes nothing
    if (!open_cur || !beat_valid) begin
      res.emit = 1'b0;
      sum_nxt  = sum_r;
      pos_nxt  = pos_r;
      slen_nxt = slen_r;
      open_nxt = open_r;
    end else if (res.emit) begin
      open_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      pos_r  <= '0;
      slen_r <= '0;
      open_r <= 1'b0;
    end else if (advance) begin
      sum_r  <= sum_nxt;
      pos_r  <= pos_nxt;
      slen_r <= slen_nxt;
      open_r <= open_nxt;
    end
  end

endmodule

@@ hw/rtl/rotate_add_checksum_engine_core.sv @@
// rotate_add_checksum_engine_core: top level, input register, fold and result register
// depends on rac_pkg, rac_in_if, rac_out_if and rac_fold
//
// Folds a byte stream into a rotate-right-by-one-then-add checksum. One byte
// beat is taken every clock cycle, unless a message end waits on a full result
// register; the result of a message passes the input register, then the result
// register. The rate is set by the rotate-add on the running sum, which is
// updated once per beat. Modes (cfg_wdata): 0 boot region, 32-bit, bytes 106,
// 107 and 112 skipped; 1 entry set, 16-bit, bytes 2 and 3 skipped, length taken
// from byte 1, short_set flags a set cut off by last_byte; 2 or 3 plain 32-bit.
// A beat with first_byte restarts the sum; beats outside a message are
// dropped. Write the mode only while the engine is idle.
module rotate_add_checksum_engine_core #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,
  rac_in_if.sink      in_chan,
  rac_out_if.source   out_chan
);

  rac_pkg::mode_t     mode_r;
  rac_pkg::beat_t     beat_r;
  logic               beat_valid_r;
  rac_pkg::fold_res_t res;
  logic               out_free, fold_adv;
  logic               out_valid_r;
  logic [rac_pkg::SUM_W-1:0] out_sum_r;
  logic               out_short_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= rac_pkg::MODE_BOOT;
    end else if (cfg_we) begin
      mode_r <= rac_pkg::mode_t'(cfg_wdata);
    end
  end

  assign out_free     = ~out_valid_r | out_chan.ready;
  assign fold_adv     = beat_valid_r & (~res.emit | out_free);
  assign in_chan.ready = ~beat_valid_r | fold_adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_valid_r <= 1'b0;
    end else if (in_chan.valid && in_chan.ready) begin
      beat_valid_r <= 1'b1;
    end else if (fold_adv) begin
      beat_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      beat_r.data_byte  <= in_chan.data_byte;
      beat_r.first_byte <= in_chan.first_byte;
      beat_r.last_byte  <= in_chan.last_byte;
    end
  end

  rac_fold #(
    .POSITION_BITS (POSITION_BITS)
  ) u_fold (
    .clk        (clk),
    .rst_n      (rst_n),
    .mode       (mode_r),
    .beat       (beat_r),
    .beat_valid (beat_valid_r),
    .advance    (fold_adv),
    .res        (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fold_adv && res.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fold_adv && res.emit) begin
      out_sum_r   <= res.checksum_value;
      out_short_r <= res.short_set;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.checksum_value = out_sum_r;
  assign out_chan.short_set      = out_short_r;

endmodule
